// ===== src/rtoe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtoe_pkg
// Shared types and constants of the retransmission timeout estimator.
// ----------------------------------------------------------------------------
package rtoe_pkg;

  // operation codes
  localparam logic [1:0] OP_RESTART      = 2'd0;
  localparam logic [1:0] OP_ACK_SAMPLE   = 2'd1;
  localparam logic [1:0] OP_ACK_NOSAMPLE = 2'd2;
  localparam logic [1:0] OP_TIMEOUT      = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RTO_MIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RTO_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RTO_INITIAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RETRY_LIMIT = 2'd3;

  // configuration reset values
  localparam logic [15:0] RTO_MIN_RESET     = 16'd200;
  localparam logic [15:0] RTO_MAX_RESET     = 16'd60000;
  localparam logic [15:0] RTO_INITIAL_RESET = 16'd1000;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd6;

  // retry counter saturates here, always above any retry limit
  localparam logic [4:0] RETRY_SAT = 5'd16;
  // floor of the variance term added to srtt
  localparam int unsigned SPREAD_MIN = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] rtt_ticks;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rto_value;
    logic [15:0] smoothed_rtt;
    logic [15:0] rtt_deviation;
    logic [4:0]  retry_count;
    logic        give_up;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rto_min;
    logic [15:0] rto_max;
    logic [15:0] rto_initial;
    logic [3:0]  retry_limit;
  } cfg_t;

endpackage

// ===== src/rtoe_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtoe_cfg
// Configuration register file: clamps, initial timeout and retry limit.
// ----------------------------------------------------------------------------
module rtoe_cfg
  import rtoe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rto_min     <= RTO_MIN_RESET;
      cfg.rto_max     <= RTO_MAX_RESET;
      cfg.rto_initial <= RTO_INITIAL_RESET;
      cfg.retry_limit <= RETRY_LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IDX_RTO_MIN:     cfg.rto_min     <= wr_data;
        CFG_IDX_RTO_MAX:     cfg.rto_max     <= wr_data;
        CFG_IDX_RTO_INITIAL: cfg.rto_initial <= wr_data;
        CFG_IDX_RETRY_LIMIT: cfg.retry_limit <= wr_data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/rtoe_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtoe_engine
// Estimator state and its update for one operation.
// ----------------------------------------------------------------------------
module rtoe_engine
  import rtoe_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int unsigned T  = TIME_BITS;
  localparam int unsigned SW = (T > 16) ? T : 16;
  localparam int unsigned CW = (T + 3 > 16) ? T + 3 : 16;
  localparam logic [T-1:0] TMAX = '1;

  logic [T-1:0] srtt, rttvar, rto;
  logic [4:0]   retry;
  logic         failed, seeded;
  logic [T-1:0] srtt_next, rttvar_next, rto_next;
  logic [4:0]   retry_next;
  logic         failed_next, seeded_next;

  logic [SW-1:0]  samp_ext, samp_sat, init_ext, init_sat;
  logic [T-1:0]   fold_in, diff, srtt_fold, rttvar_fold, rto_fold, rto_init, rto_dbl;
  logic [T+1:0]   var_sum, spread4, spread;
  logic [T+2:0]   srtt_sum, rto_sum;
  logic [CW-1:0]  rto_c, min_c, max_c, clamp_c, dbl_c, dbl_cap;
  logic [4:0]     retry_inc;
  logic           give;

  function automatic logic [15:0] to_field(input logic [T-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return w[15:0];
  endfunction

  always_comb begin
    // saturate the sample to the time width
    samp_ext = SW'(item.rtt_ticks);
    samp_sat = (samp_ext > SW'(TMAX)) ? SW'(TMAX) : samp_ext;
    fold_in  = (item.operation == OP_ACK_SAMPLE) ? samp_sat[T-1:0] : srtt;

    diff     = (srtt > fold_in) ? srtt - fold_in : fold_in - srtt;
    var_sum  = {1'b0, rttvar, 1'b0} + (T+2)'(rttvar) + (T+2)'(diff);
    srtt_sum = {srtt, 3'b000} - (T+3)'(srtt) + (T+3)'(fold_in);

    if (seeded) begin
      srtt_fold   = srtt_sum[T+2:3];
      rttvar_fold = var_sum[T+1:2];
    end else begin
      srtt_fold   = (fold_in == '0) ? T'(1) : fold_in;
      rttvar_fold = fold_in >> 1;
    end

    spread4 = {rttvar_fold, 2'b00};
    spread  = (spread4 > (T+2)'(SPREAD_MIN)) ? spread4 : (T+2)'(SPREAD_MIN);
    rto_sum = (T+3)'(srtt_fold) + (T+3)'(spread);

    // lower clamp takes priority, then saturate
    rto_c = CW'(rto_sum);
    min_c = CW'(cfg.rto_min);
    max_c = CW'(cfg.rto_max);
    if (rto_c < min_c) begin
      clamp_c = min_c;
    end else if (rto_c > max_c) begin
      clamp_c = max_c;
    end else begin
      clamp_c = rto_c;
    end
    rto_fold = (clamp_c > CW'(TMAX)) ? TMAX : clamp_c[T-1:0];

    init_ext = SW'(cfg.rto_initial);
    init_sat = (init_ext > SW'(TMAX)) ? SW'(TMAX) : init_ext;
    rto_init = init_sat[T-1:0];

    // backoff: double, cap at rto_max, saturate
    dbl_c   = CW'({rto, 1'b0});
    dbl_cap = (dbl_c > max_c) ? max_c : dbl_c;
    rto_dbl = (dbl_cap > CW'(TMAX)) ? TMAX : dbl_cap[T-1:0];

    retry_inc = (retry < RETRY_SAT) ? retry + 5'd1 : retry;
    give      = retry_inc > {1'b0, cfg.retry_limit};

    srtt_next   = srtt;
    rttvar_next = rttvar;
    rto_next    = rto;
    retry_next  = retry;
    failed_next = failed;
    seeded_next = seeded;
    case (item.operation)
      OP_RESTART: begin
        srtt_next   = '0;
        rttvar_next = '0;
        rto_next    = rto_init;
        retry_next  = '0;
        failed_next = 1'b0;
        seeded_next = 1'b0;
      end
      OP_ACK_SAMPLE: begin
        srtt_next   = srtt_fold;
        rttvar_next = rttvar_fold;
        rto_next    = rto_fold;
        retry_next  = '0;
        seeded_next = 1'b1;
      end
      OP_ACK_NOSAMPLE: begin
        if (seeded) begin
          srtt_next   = srtt_fold;
          rttvar_next = rttvar_fold;
          rto_next    = rto_fold;
        end
        retry_next = '0;
      end
      OP_TIMEOUT: begin
        if (!failed) begin
          retry_next = retry_inc;
          if (give) begin
            failed_next = 1'b1;
          end else begin
            rto_next = rto_dbl;
          end
        end
      end
      default: begin
      end
    endcase

    result.rto_value     = to_field(rto_next);
    result.smoothed_rtt  = to_field(srtt_next);
    result.rtt_deviation = to_field(rttvar_next);
    result.retry_count   = retry_next;
    result.give_up       = failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt   <= '0;
      rttvar <= '0;
      rto    <= T'(RTO_INITIAL_RESET);
      retry  <= '0;
      failed <= 1'b0;
      seeded <= 1'b0;
    end else if (en) begin
      srtt   <= srtt_next;
      rttvar <= rttvar_next;
      rto    <= rto_next;
      retry  <= retry_next;
      failed <= failed_next;
      seeded <= seeded_next;
    end
  end

  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    retry <= RETRY_SAT)
    else $error("retry counter above saturation");

  a_give_up_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && !(en && item.operation == OP_RESTART) |=> failed)
    else $error("give_up cleared without restart");

  a_timeout_after_fail: assert property (@(posedge clk) disable iff (rst)
    en && failed && item.operation == OP_TIMEOUT |=> $stable(rto) && $stable(retry))
    else $error("timeout after give_up changed state");

  // srtt may decay to zero later, so only the seeded mark is required
  a_seed_on_sample: assert property (@(posedge clk) disable iff (rst)
    en && item.operation == OP_ACK_SAMPLE |=> seeded)
    else $error("sample did not seed the estimator");

endmodule

// ===== src/tcp_rto_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_rto_estimator_top
// Retransmission timeout estimator with backoff and retry limit.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle when the output side does not stall and
// returns one result item for each. An accepted item waits in an input
// register until the result register is free; in the cycle it moves on to
// the result register, from which it is offered at the output, the estimator
// state (srtt, rttvar, rto, retries, give_up) is updated by a single pass of
// combinational logic and the values after the update go to the result
// register. The state feeds back on itself in that same cycle, so the next
// item sees the result of this one with no bubble. The sustained rate is set
// by that state loop: one item per cycle unless the output stalls. When
// out_ready is low the result register holds, the input register still takes
// one more item, and in_ready drops only once both are full. Configuration
// writes are always taken (cfg_ready stays high) and should only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module tcp_rto_estimator_top
  import rtoe_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid, s1_valid_next;
  logic      out_valid_next;
  logic      advance, in_take;
  out_item_t result;

  // writes never stall
  assign cfg_ready = 1'b1;

  rtoe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // move the held item through the estimator when the result slot is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_take  = in_valid && in_ready;

  rtoe_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers: hold until the next item replaces them
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty input register");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready && !advance)
    else $error("item moved while both registers were full and stalled");

endmodule
